// File: hw/rtl/point_vs_segment_geometry_top_defines.svh
// ----------------------------------------------------------------------------
// Point vs segment geometry: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef POINT_VS_SEGMENT_GEOMETRY_TOP_DEFINES_SVH
`define POINT_VS_SEGMENT_GEOMETRY_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define PSG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("psg checker: implication violated");

// fixed-delay implication, off during reset
`define PSG_ASSERT_DLY(lbl, clk, rstn, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##n (cons)) \
    else $error("psg checker: delayed response violated");

`endif

// File: hw/rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared constants and types of the point vs segment geometry block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psg_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS       = 8;
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X = 2'd0,
    CFG_START_Y = 2'd1,
    CFG_END_X   = 2'd2,
    CFG_END_Y   = 2'd3
  } cfg_idx_e;

  localparam logic [1:0] SIDE_ON    = 2'b00;
  localparam logic [1:0] SIDE_LEFT  = 2'b01;
  localparam logic [1:0] SIDE_RIGHT = 2'b11;

  typedef struct packed {
    logic [1:0] side;
    logic       on_seg;
    logic       degen;
    logic       use_end;
    logic       neg_x;
    logic       neg_y;
  } flags_t;

  // request-to-result latency in cycles
  function automatic int pipe_latency(input int w);
    return w + 8;
  endfunction

endpackage

// File: hw/rtl/psg_root.sv
// ----------------------------------------------------------------------------
// psg_root
// Pipelined root search: largest r with r*r*l <= n, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_root
  import psg_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic [4*COORD_WIDTH+8:0]   n_i,
  input  logic [2*COORD_WIDTH:0]     l_i,
  output logic [COORD_WIDTH+2:0]     r_o
);

  localparam int K  = COORD_WIDTH + 3;
  localparam int NR = 4 * COORD_WIDTH + 9;
  localparam int UW = 3 * COORD_WIDTH + 5;
  localparam int LW = 2 * COORD_WIDTH + 1;

  // t = r*r*l, u = r*l kept incrementally
  logic [NR-1:0] n_in [K];
  logic [NR-1:0] t_in [K];
  logic [UW-1:0] u_in [K];
  logic [LW-1:0] l_in [K];
  logic [K-1:0]  r_in [K];

  logic [NR-1:0] n_q [K];
  logic [NR-1:0] t_q [K];
  logic [UW-1:0] u_q [K];
  logic [LW-1:0] l_q [K];
  logic [K-1:0]  r_q [K];

  for (genvar j = 0; j < K; j++) begin : g_stage
    localparam int B = K - 1 - j;
    logic [NR-1:0] cand;

    if (j == 0) begin : g_first
      assign n_in[j] = n_i;
      assign t_in[j] = '0;
      assign u_in[j] = '0;
      assign l_in[j] = l_i;
      assign r_in[j] = '0;
    end else begin : g_next
      assign n_in[j] = n_q[j-1];
      assign t_in[j] = t_q[j-1];
      assign u_in[j] = u_q[j-1];
      assign l_in[j] = l_q[j-1];
      assign r_in[j] = r_q[j-1];
    end

    // (r + 2^B)^2 l = t + 2^(B+1) u + 2^(2B) l
    assign cand = t_in[j] + (NR'(u_in[j]) << (B + 1)) + (NR'(l_in[j]) << (2 * B));

    always_ff @(posedge clk_i) begin
      n_q[j] <= n_in[j];
      l_q[j] <= l_in[j];
      if (cand <= n_in[j]) begin
        t_q[j] <= cand;
        u_q[j] <= u_in[j] + (UW'(l_in[j]) << B);
        r_q[j] <= r_in[j] | (K'(1) << B);
      end else begin
        t_q[j] <= t_in[j];
        u_q[j] <= u_in[j];
        r_q[j] <= r_in[j];
      end
    end
  end

  assign r_o = r_q[K-1];

endmodule

// File: hw/rtl/psg_div.sv
// ----------------------------------------------------------------------------
// psg_div
// Pipelined restoring divider with a bounded quotient, one bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_div
  import psg_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic [3*COORD_WIDTH+4:0]   n_i,
  input  logic [2*COORD_WIDTH:0]     l_i,
  output logic [COORD_WIDTH+2:0]     q_o
);

  localparam int K  = COORD_WIDTH + 3;
  localparam int ND = 3 * COORD_WIDTH + 5;
  localparam int LW = 2 * COORD_WIDTH + 1;

  logic [ND-1:0] rem_in [K];
  logic [LW-1:0] l_in   [K];
  logic [K-1:0]  q_in   [K];

  logic [ND-1:0] rem_q [K];
  logic [LW-1:0] l_q   [K];
  logic [K-1:0]  q_q   [K];

  for (genvar j = 0; j < K; j++) begin : g_stage
    localparam int B = K - 1 - j;
    logic [ND-1:0] sub;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in[j] = n_i;
      assign l_in[j]   = l_i;
      assign q_in[j]   = '0;
    end else begin : g_next
      assign rem_in[j] = rem_q[j-1];
      assign l_in[j]   = l_q[j-1];
      assign q_in[j]   = q_q[j-1];
    end

    assign sub = ND'(l_in[j]) << B;
    assign ge  = (rem_in[j] >= sub);

    always_ff @(posedge clk_i) begin
      l_q[j]   <= l_in[j];
      rem_q[j] <= ge ? (rem_in[j] - sub) : rem_in[j];
      q_q[j]   <= ge ? (q_in[j] | (K'(1) << B)) : q_in[j];
    end
  end

  assign q_o = q_q[K-1];

endmodule

// File: hw/rtl/point_vs_segment_geometry_top.sv
// ----------------------------------------------------------------------------
// point_vs_segment_geometry_top
// Point vs segment: side, on-segment test, distances, foot and mirror image.
// ----------------------------------------------------------------------------
// Usage
//   Segment endpoints live in four registers written through cfg_we_i /
//   cfg_idx_i / cfg_data_i (start_x, start_y, end_x, end_y), one per cycle,
//   no wait. Reset loads start (0,0) and end (1.0,0), in Q8.8.
//   A query request is taken at a clock edge with start_i high and busy_o
//   low. busy_o stays low: the pipeline takes one point every cycle.
//   Each result shows for exactly one cycle with done_o high, in request
//   order.
//   Stages: differences, products, magnitudes / split products, operand
//   assembly, then COORD_WIDTH+3 bit stages of two root searches and two
//   dividers running side by side, then rounding, clipping and the output
//   register. The bit-serial root and divide stages set the latency.
//   The receiver cannot stall, so nothing is held back; reset drops
//   whatever is in flight.
//   Coordinates are signed Q8.8 at the default width; distances are
//   unsigned with one more integer bit. Clipped results raise saturated_o;
//   a zero-length segment raises degenerate_o.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_vs_segment_geometry_top
  import psg_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // query channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  // result channel
  output logic                          done_o,
  output logic signed [1:0]             side_o,
  output logic                          on_segment_o,
  output logic [COORD_WIDTH:0]          line_distance_o,
  output logic [COORD_WIDTH:0]          segment_distance_o,
  output logic signed [COORD_WIDTH-1:0] foot_x_o,
  output logic signed [COORD_WIDTH-1:0] foot_y_o,
  output logic signed [COORD_WIDTH-1:0] mirror_x_o,
  output logic signed [COORD_WIDTH-1:0] mirror_y_o,
  output logic                          degenerate_o,
  output logic                          saturated_o
);

  localparam int W  = COORD_WIDTH;
  localparam int K  = W + 3;          // bit stages in the root / divide units
  localparam int DW = W + 1;          // coordinate differences
  localparam int PW = 2 * W + 2;      // single products
  localparam int CW = 2 * W + 3;      // sums of two products
  localparam int LW = 2 * W + 1;      // squared lengths
  localparam int SW = 2 * W + 1;      // magnitudes of cross / dot
  localparam int SL = W + 1;          // low half of a split operand
  localparam int NR = 4 * W + 9;      // root operand
  localparam int ND = 3 * W + 5;      // divider operand
  localparam int EW = W + 5;          // foot / mirror before clipping

  localparam logic [W-1:0]          EndXRst = W'(1 << FRAC_BITS);
  localparam logic [K:0]            DMax    = {3'b000, {(W + 1){1'b1}}};
  localparam logic signed [EW-1:0]  CMaxE   = {6'b000000, {(W - 1){1'b1}}};
  localparam logic signed [EW-1:0]  CMinE   = {6'b111111, {(W - 1){1'b0}}};

  // ---------------------------------------------------------------- config
  logic signed [W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= EndXRst;
      end_y_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_X: start_x_q <= cfg_data_i;
        CFG_START_Y: start_y_q <= cfg_data_i;
        CFG_END_X:   end_x_q   <= cfg_data_i;
        CFG_END_Y:   end_y_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // never stalls
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // ------------------------------------------------------- stage 1: deltas
  logic signed [DW-1:0] dx_d, dy_d, ax_d, ay_d, bx_d, by_d;
  logic signed [DW-1:0] dx1_q, dy1_q, ax1_q, ay1_q, bx1_q, by1_q;
  logic signed [W-1:0]  sx1_q, sy1_q, px1_q, py1_q;
  logic                 v1_q;

  assign dx_d = {end_x_q[W-1], end_x_q} - {start_x_q[W-1], start_x_q};
  assign dy_d = {end_y_q[W-1], end_y_q} - {start_y_q[W-1], start_y_q};
  assign ax_d = {point_x_i[W-1], point_x_i} - {start_x_q[W-1], start_x_q};
  assign ay_d = {point_y_i[W-1], point_y_i} - {start_y_q[W-1], start_y_q};
  assign bx_d = {point_x_i[W-1], point_x_i} - {end_x_q[W-1], end_x_q};
  assign by_d = {point_y_i[W-1], point_y_i} - {end_y_q[W-1], end_y_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx1_q <= dx_d;
      dy1_q <= dy_d;
      ax1_q <= ax_d;
      ay1_q <= ay_d;
      bx1_q <= bx_d;
      by1_q <= by_d;
      sx1_q <= start_x_q;
      sy1_q <= start_y_q;
      px1_q <= point_x_i;
      py1_q <= point_y_i;
    end
  end

  // ----------------------------------------------------- stage 2: products
  logic signed [PW-1:0] p_dxay, p_dyax, p_dxdx, p_dydy, p_axdx, p_aydy;
  logic signed [PW-1:0] p_bxdx, p_bydy, p_axbx, p_ayby, p_axax, p_ayay;
  logic signed [PW-1:0] p_bxbx, p_byby;

  assign p_dxay = PW'(dx1_q) * PW'(ay1_q);
  assign p_dyax = PW'(dy1_q) * PW'(ax1_q);
  assign p_dxdx = PW'(dx1_q) * PW'(dx1_q);
  assign p_dydy = PW'(dy1_q) * PW'(dy1_q);
  assign p_axdx = PW'(ax1_q) * PW'(dx1_q);
  assign p_aydy = PW'(ay1_q) * PW'(dy1_q);
  assign p_bxdx = PW'(bx1_q) * PW'(dx1_q);
  assign p_bydy = PW'(by1_q) * PW'(dy1_q);
  assign p_axbx = PW'(ax1_q) * PW'(bx1_q);
  assign p_ayby = PW'(ay1_q) * PW'(by1_q);
  assign p_axax = PW'(ax1_q) * PW'(ax1_q);
  assign p_ayay = PW'(ay1_q) * PW'(ay1_q);
  assign p_bxbx = PW'(bx1_q) * PW'(bx1_q);
  assign p_byby = PW'(by1_q) * PW'(by1_q);

  logic signed [PW-1:0] len_sum, d1_sum, d2_sum;
  assign len_sum = p_dxdx + p_dydy;
  assign d1_sum  = p_axax + p_ayay;
  assign d2_sum  = p_bxbx + p_byby;

  logic signed [CW-1:0] cross2_q, dots2_q, dote2_q, dpe2_q;
  logic [LW-1:0]        len2_q, d12_q, d22_q;
  logic signed [DW-1:0] dx2_q, dy2_q;
  logic signed [W-1:0]  sx2_q, sy2_q, px2_q, py2_q;
  logic                 v2_q;

  always_ff @(posedge clk_i) begin
    cross2_q <= CW'(p_dxay) - CW'(p_dyax);
    dots2_q  <= CW'(p_axdx) + CW'(p_aydy);
    dote2_q  <= CW'(p_bxdx) + CW'(p_bydy);
    dpe2_q   <= CW'(p_axbx) + CW'(p_ayby);
    len2_q   <= LW'(len_sum);
    d12_q    <= LW'(d1_sum);
    d22_q    <= LW'(d2_sum);
    dx2_q    <= dx1_q;
    dy2_q    <= dy1_q;
    sx2_q    <= sx1_q;
    sy2_q    <= sy1_q;
    px2_q    <= px1_q;
    py2_q    <= py1_q;
  end

  // ---------------------------------- stage 3: magnitudes, split products
  logic [CW-1:0] cross_abs, dots_abs;
  logic [SW-1:0] s_mag, dot_mag;
  logic [W-1:0]  dxm, dym;

  assign cross_abs = cross2_q[CW-1] ? CW'(-cross2_q) : CW'(cross2_q);
  assign dots_abs  = dots2_q[CW-1] ? CW'(-dots2_q) : CW'(dots2_q);
  assign s_mag     = cross_abs[SW-1:0];
  assign dot_mag   = dots_abs[SW-1:0];
  assign dxm       = W'(dx2_q[DW-1] ? -dx2_q : dx2_q);
  assign dym       = W'(dy2_q[DW-1] ? -dy2_q : dy2_q);

  flags_t flg_d;
  always_comb begin
    flg_d.side    = (cross2_q == '0) ? SIDE_ON : (cross2_q[CW-1] ? SIDE_RIGHT : SIDE_LEFT);
    flg_d.on_seg  = (cross2_q == '0) && (dpe2_q <= 0);
    flg_d.degen   = (len2_q == '0);
    flg_d.use_end = (dots2_q < 0) || (dote2_q > 0);
    flg_d.neg_x   = dx2_q[DW-1] ^ dots2_q[CW-1];
    flg_d.neg_y   = dy2_q[DW-1] ^ dots2_q[CW-1];
  end

  logic [2*W-1:0]   sq_hh3_q, nxh3_q, nyh3_q;
  logic [2*W:0]     sq_hl3_q, nxl3_q, nyl3_q;
  logic [2*W+1:0]   sq_ll3_q;
  logic [LW-1:0]    m3_q, len3_q;
  flags_t           flg3_q;
  logic signed [W-1:0] sx3_q, sy3_q, px3_q, py3_q;
  logic             v3_q;

  always_ff @(posedge clk_i) begin
    // cross^2 from halves
    sq_hh3_q <= (2*W)'(s_mag[SW-1:SL]) * (2*W)'(s_mag[SW-1:SL]);
    sq_hl3_q <= (2*W+1)'(s_mag[SW-1:SL]) * (2*W+1)'(s_mag[SL-1:0]);
    sq_ll3_q <= (2*W+2)'(s_mag[SL-1:0]) * (2*W+2)'(s_mag[SL-1:0]);
    // |d| * |dot| from halves
    nxh3_q   <= (2*W)'(dxm) * (2*W)'(dot_mag[SW-1:SL]);
    nxl3_q   <= (2*W+1)'(dxm) * (2*W+1)'(dot_mag[SL-1:0]);
    nyh3_q   <= (2*W)'(dym) * (2*W)'(dot_mag[SW-1:SL]);
    nyl3_q   <= (2*W+1)'(dym) * (2*W+1)'(dot_mag[SL-1:0]);
    m3_q     <= (d12_q <= d22_q) ? d12_q : d22_q;
    len3_q   <= len2_q;
    flg3_q   <= flg_d;
    sx3_q    <= sx2_q;
    sy3_q    <= sy2_q;
    px3_q    <= px2_q;
    py3_q    <= py2_q;
  end

  // ------------------------------------------- stage 4: operand assembly
  logic [NR-1:0] nline4_q, nseg4_q;
  logic [ND-1:0] nx4_q, ny4_q;
  logic [LW-1:0] len4_q;
  flags_t        flg4_q;
  logic signed [W-1:0] sx4_q, sy4_q, px4_q, py4_q;
  logic          v4_q;

  always_ff @(posedge clk_i) begin
    nline4_q <= ((NR'(sq_hh3_q) << (2 * SL)) + (NR'(sq_hl3_q) << (SL + 1))
                 + NR'(sq_ll3_q)) << 2;
    nseg4_q  <= NR'(m3_q) << 2;
    nx4_q    <= ((ND'(nxh3_q) << SL) + ND'(nxl3_q)) << 2;
    ny4_q    <= ((ND'(nyh3_q) << SL) + ND'(nyl3_q)) << 2;
    len4_q   <= len3_q;
    flg4_q   <= flg3_q;
    sx4_q    <= sx3_q;
    sy4_q    <= sy3_q;
    px4_q    <= px3_q;
    py4_q    <= py3_q;
  end

  // --------------------------------------------- bit-serial stage units
  logic [K-1:0] r_line, r_seg, g_x, g_y;

  psg_root #(.COORD_WIDTH(COORD_WIDTH)) u_root_line (
    .clk_i (clk_i),
    .n_i   (nline4_q),
    .l_i   (len4_q),
    .r_o   (r_line)
  );

  psg_root #(.COORD_WIDTH(COORD_WIDTH)) u_root_seg (
    .clk_i (clk_i),
    .n_i   (nseg4_q),
    .l_i   (LW'(1)),
    .r_o   (r_seg)
  );

  psg_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_x (
    .clk_i (clk_i),
    .n_i   (nx4_q),
    .l_i   (len4_q),
    .q_o   (g_x)
  );

  psg_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_y (
    .clk_i (clk_i),
    .n_i   (ny4_q),
    .l_i   (len4_q),
    .q_o   (g_y)
  );

  // sideband runs alongside the unit stages
  flags_t              flg_q [K];
  logic signed [W-1:0] sx_q [K];
  logic signed [W-1:0] sy_q [K];
  logic signed [W-1:0] px_q [K];
  logic signed [W-1:0] py_q [K];
  logic [K-1:0]        vld_q;

  always_ff @(posedge clk_i) begin
    flg_q[0] <= flg4_q;
    sx_q[0]  <= sx4_q;
    sy_q[0]  <= sy4_q;
    px_q[0]  <= px4_q;
    py_q[0]  <= py4_q;
    for (int i = 1; i < K; i++) begin
      flg_q[i] <= flg_q[i-1];
      sx_q[i]  <= sx_q[i-1];
      sy_q[i]  <= sy_q[i-1];
      px_q[i]  <= px_q[i-1];
      py_q[i]  <= py_q[i-1];
    end
  end

  // ------------------------------------------- rounding and clipping
  flags_t              fl;
  logic signed [W-1:0] sxf, syf, pxf, pyf;
  assign fl  = flg_q[K-1];
  assign sxf = sx_q[K-1];
  assign syf = sy_q[K-1];
  assign pxf = px_q[K-1];
  assign pyf = py_q[K-1];

  logic [K-1:0] r_sel;
  logic [K:0]   lw_full, sw_full;
  logic         ld_sat, sd_sat;

  assign r_sel   = fl.use_end ? r_seg : r_line;
  assign lw_full = ({1'b0, r_line} + (K+1)'(1)) >> 1;
  assign sw_full = ({1'b0, r_sel} + (K+1)'(1)) >> 1;
  assign ld_sat  = (lw_full > DMax);
  assign sd_sat  = (sw_full > DMax);

  // g = floor(4|n|/len): round(|n|/len) and round(2|n|/len), ties away
  logic [K:0] q1x, q1y, q2x, q2y;
  assign q1x = (({1'b0, g_x} >> 1) + (K+1)'(1)) >> 1;
  assign q1y = (({1'b0, g_y} >> 1) + (K+1)'(1)) >> 1;
  assign q2x = ({1'b0, g_x} + (K+1)'(1)) >> 1;
  assign q2y = ({1'b0, g_y} + (K+1)'(1)) >> 1;

  logic signed [EW-1:0] q1x_e, q1y_e, q2x_e, q2y_e;
  logic signed [EW-1:0] sx_e, sy_e, px_e, py_e;
  logic signed [EW-1:0] fx_w, fy_w, mx_w, my_w;

  assign q1x_e = EW'(q1x);
  assign q1y_e = EW'(q1y);
  assign q2x_e = EW'(q2x);
  assign q2y_e = EW'(q2y);
  assign sx_e  = EW'(sxf);
  assign sy_e  = EW'(syf);
  assign px_e  = EW'(pxf);
  assign py_e  = EW'(pyf);

  assign fx_w = sx_e + (fl.neg_x ? -q1x_e : q1x_e);
  assign fy_w = sy_e + (fl.neg_y ? -q1y_e : q1y_e);
  assign mx_w = sx_e + sx_e - px_e + (fl.neg_x ? -q2x_e : q2x_e);
  assign my_w = sy_e + sy_e - py_e + (fl.neg_y ? -q2y_e : q2y_e);

  // {clipped, value}
  function automatic logic [W:0] clip_coord(input logic signed [EW-1:0] v);
    logic [W:0] res;
    if (v > CMaxE) begin
      res = {1'b1, CMaxE[W-1:0]};
    end else if (v < CMinE) begin
      res = {1'b1, CMinE[W-1:0]};
    end else begin
      res = {1'b0, v[W-1:0]};
    end
    return res;
  endfunction

  logic [W:0] fx_c, fy_c, mx_c, my_c;
  assign fx_c = clip_coord(fx_w);
  assign fy_c = clip_coord(fy_w);
  assign mx_c = clip_coord(mx_w);
  assign my_c = clip_coord(my_w);

  // ----------------------------------------------------- output register
  logic signed [1:0]   side_d;
  logic                on_seg_d, degen_d, sat_d;
  logic [W:0]          ld_d, sd_d;
  logic signed [W-1:0] fx_d, fy_d, mx_d, my_d;

  always_comb begin
    side_d   = fl.side;
    on_seg_d = fl.on_seg;
    degen_d  = fl.degen;
    if (fl.degen) begin
      // zero-length segment: foot is start, mirror is the point itself
      ld_d  = '0;
      sd_d  = '0;
      fx_d  = sxf;
      fy_d  = syf;
      mx_d  = pxf;
      my_d  = pyf;
      sat_d = 1'b0;
    end else begin
      ld_d  = ld_sat ? DMax[W:0] : lw_full[W:0];
      sd_d  = sd_sat ? DMax[W:0] : sw_full[W:0];
      fx_d  = fx_c[W-1:0];
      fy_d  = fy_c[W-1:0];
      mx_d  = mx_c[W-1:0];
      my_d  = my_c[W-1:0];
      sat_d = ld_sat | sd_sat | fx_c[W] | fy_c[W] | mx_c[W] | my_c[W];
    end
  end

  logic signed [1:0]   side_q;
  logic                on_seg_q, degen_q, sat_q, done_q;
  logic [W:0]          ld_q, sd_q;
  logic signed [W-1:0] fx_q, fy_q, mx_q, my_q;

  always_ff @(posedge clk_i) begin
    side_q   <= side_d;
    on_seg_q <= on_seg_d;
    degen_q  <= degen_d;
    sat_q    <= sat_d;
    ld_q     <= ld_d;
    sd_q     <= sd_d;
    fx_q     <= fx_d;
    fy_q     <= fy_d;
    mx_q     <= mx_d;
    my_q     <= my_d;
  end

  // valid chain, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      vld_q  <= {vld_q[K-2:0], v4_q};
      done_q <= vld_q[K-1];
    end
  end

  assign done_o             = done_q;
  assign side_o             = side_q;
  assign on_segment_o       = on_seg_q;
  assign line_distance_o    = ld_q;
  assign segment_distance_o = sd_q;
  assign foot_x_o           = fx_q;
  assign foot_y_o           = fy_q;
  assign mirror_x_o         = mx_q;
  assign mirror_y_o         = my_q;
  assign degenerate_o       = degen_q;
  assign saturated_o        = sat_q;

endmodule

// File: hw/rtl/psg_checker.sv
// ----------------------------------------------------------------------------
// psg_checker
// Port-level assertions for the point vs segment geometry block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_vs_segment_geometry_top_defines.svh"

module psg_checker
  import psg_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic signed [1:0]             side_o,
  input logic                          on_segment_o,
  input logic [COORD_WIDTH:0]          line_distance_o,
  input logic [COORD_WIDTH:0]          segment_distance_o,
  input logic                          degenerate_o,
  input logic                          saturated_o
);

  localparam int Lat = pipe_latency(COORD_WIDTH);

  // every request gets its result after the fixed latency
  `PSG_ASSERT_DLY(a_latency, clk_i, rst_ni, start_i && !busy_o, Lat, done_o)

  // a point on the segment lies on the line
  `PSG_ASSERT_IMP(a_onseg_side, clk_i, rst_ni, done_o && on_segment_o, side_o == SIDE_ON)

  // zero-length segment reports no distance and no clipping
  `PSG_ASSERT_IMP(a_degen, clk_i, rst_ni, done_o && degenerate_o, line_distance_o == '0 && segment_distance_o == '0 && !saturated_o)

  // the segment is never nearer than the line
  `PSG_ASSERT_IMP(a_seg_ge_line, clk_i, rst_ni, done_o && !saturated_o, segment_distance_o >= line_distance_o)

endmodule

bind point_vs_segment_geometry_top psg_checker #(.COORD_WIDTH(COORD_WIDTH)) u_psg_checker (.*);
